// File: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property that holds at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/dhjt_pkg.sv
// ---------------------------------------------------------------------------
// dhjt_pkg
// Shared constants and types for the DH joint transform.
// ---------------------------------------------------------------------------
package dhjt_pkg;

  localparam int CORDIC_STEPS = 31;
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

  localparam logic [2:0] CFG_ANGLE_OFFSET = 3'd0;
  localparam logic [2:0] CFG_LINK_LENGTH  = 3'd1;
  localparam logic [2:0] CFG_LINK_OFFSET  = 3'd2;
  localparam logic [2:0] CFG_TWIST_ANGLE  = 3'd3;
  localparam logic [2:0] CFG_JOINT_KIND   = 3'd4;

  localparam logic [1:0] KIND_REVOLUTE  = 2'd0;
  localparam logic [1:0] KIND_PRISMATIC = 2'd1;
  localparam logic [1:0] KIND_NONE      = 2'd2;
  localparam logic [1:0] KIND_SPARE     = 2'd3;

  // one CORDIC rotator state, widened to 34 bits for headroom
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } rot_t;

  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
        3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
        9: t = 32'h00145F2E;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
        15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
        21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
        24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
        27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
        default: t = 32'h00000000;
      endcase
      return t;
    end
  endfunction

endpackage

// File: rtl/dhjt_cordic_cell.sv
// ---------------------------------------------------------------------------
// dhjt_cordic_cell
// One CORDIC rotation step for theta and alpha, with a register to the next cell.
// ---------------------------------------------------------------------------
module dhjt_cordic_cell #(
  parameter int STEP = 0,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_in,
  input  dhjt_pkg::rot_t      th_in,
  input  dhjt_pkg::rot_t      al_in,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                vld_out,
  output dhjt_pkg::rot_t      th_out,
  output dhjt_pkg::rot_t      al_out,
  output logic [SIDE_W-1:0]   side_out
);

  localparam logic signed [33:0] ATAN = $signed({2'b00, dhjt_pkg::atan_turns(STEP)});

  logic                vld_r;
  dhjt_pkg::rot_t      th_r, al_r, th_nxt, al_nxt;
  logic [SIDE_W-1:0]   side_r;

  function automatic dhjt_pkg::rot_t step(input dhjt_pkg::rot_t s);
    dhjt_pkg::rot_t o;
    logic signed [33:0] dx, dy;
    begin
      dx = s.y >>> STEP;
      dy = s.x >>> STEP;
      if (!s.z[33]) begin
        o.x = s.x - dx; o.y = s.y + dy; o.z = s.z - ATAN;
      end else begin
        o.x = s.x + dx; o.y = s.y - dy; o.z = s.z + ATAN;
      end
      return o;
    end
  endfunction

  always_comb begin
    th_nxt = step(th_in);
    al_nxt = step(al_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    th_r   <= th_nxt;
    al_r   <= al_nxt;
    side_r <= side_in;
  end

  assign vld_out  = vld_r;
  assign th_out   = th_r;
  assign al_out   = al_r;
  assign side_out = side_r;

endmodule

// File: rtl/dh_joint_transform.sv
// Pipeline from start to out_valid: input reg, 31 CORDIC cells, quadrant map,
//   product reg, round/saturate output reg.
// Throughput: one item per cycle; busy is never raised.
// Synchronous active-low reset clears config registers and all valid bits;
//   the result receiver cannot stall, out_valid pulses one cycle per item.
module dh_joint_transform #(
  parameter int ANGLE_BITS = 24,
  parameter int LENGTH_BITS = 24,
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [LENGTH_BITS-1:0] in_joint_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          out_valid,
  output logic signed [TRIG_FRACTION_BITS+1:0] out_rot_00,
  output logic signed [TRIG_FRACTION_BITS+1:0] out_rot_01,
  output logic signed [TRIG_FRACTION_BITS+1:0] out_rot_02,
  output logic signed [TRIG_FRACTION_BITS+1:0] out_rot_10,
  output logic signed [TRIG_FRACTION_BITS+1:0] out_rot_11,
  output logic signed [TRIG_FRACTION_BITS+1:0] out_rot_12,
  output logic signed [TRIG_FRACTION_BITS+1:0] out_rot_21,
  output logic signed [TRIG_FRACTION_BITS+1:0] out_rot_22,
  output logic signed [LENGTH_BITS-1:0] out_trans_x,
  output logic signed [LENGTH_BITS-1:0] out_trans_y,
  output logic signed [LENGTH_BITS-1:0] out_trans_z
);

  localparam int F  = TRIG_FRACTION_BITS;
  localparam int TW = F + 2;
  localparam int LW = LENGTH_BITS;
  localparam int N  = dhjt_pkg::CORDIC_STEPS;
  localparam int SW = 4 + LW + LW;   // quadrants, length a, offset d
  localparam logic signed [LW:0] LMAX = (LW+1)'((64'sd1 <<< (LW-1)) - 1);
  localparam logic signed [LW:0] LMIN = -LMAX - 1;
  localparam logic signed [33:0] ONE = 34'sd1 <<< F;

  // configuration
  logic [ANGLE_BITS-1:0] ang_off_r, twist_r;
  logic signed [LW-1:0]  len_r, off_r;
  logic [1:0]            kind_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_off_r <= '0; twist_r <= '0; len_r <= '0; off_r <= '0; kind_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dhjt_pkg::CFG_ANGLE_OFFSET: ang_off_r <= cfg_data[ANGLE_BITS-1:0];
        dhjt_pkg::CFG_LINK_LENGTH:  len_r     <= cfg_data[LW-1:0];
        dhjt_pkg::CFG_LINK_OFFSET:  off_r     <= cfg_data[LW-1:0];
        dhjt_pkg::CFG_TWIST_ANGLE:  twist_r   <= cfg_data[ANGLE_BITS-1:0];
        dhjt_pkg::CFG_JOINT_KIND:   kind_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // input stage: effective angle and offset
  logic                  s0_vld_r;
  logic [ANGLE_BITS-1:0] theta_nxt, theta_r, alpha_r;
  logic signed [LW-1:0]  d_nxt, d_r, a_r;
  logic signed [LW:0]    dsum;

  always_comb begin
    theta_nxt = ang_off_r;
    d_nxt     = off_r;
    dsum      = {off_r[LW-1], off_r} + {in_joint_value[LW-1], in_joint_value};
    if (kind_r == dhjt_pkg::KIND_REVOLUTE) begin
      theta_nxt = ang_off_r + ANGLE_BITS'(unsigned'(in_joint_value));
    end else if (kind_r == dhjt_pkg::KIND_PRISMATIC) begin
      if (dsum > LMAX)      d_nxt = LMAX[LW-1:0];
      else if (dsum < LMIN) d_nxt = LMIN[LW-1:0];
      else                  d_nxt = dsum[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else        s0_vld_r <= start && !busy;
    theta_r <= theta_nxt;
    alpha_r <= twist_r;
    d_r     <= d_nxt;
    a_r     <= len_r;
  end

  // CORDIC chain
  logic [31:0]      th32, al32;
  logic             vld [N+1];
  dhjt_pkg::rot_t   th [N+1];
  dhjt_pkg::rot_t   al [N+1];
  logic [SW-1:0]    side [N+1];

  assign th32 = 32'({theta_r, 32'b0} >> ANGLE_BITS);
  assign al32 = 32'({alpha_r, 32'b0} >> ANGLE_BITS);
  assign vld[0] = s0_vld_r;
  assign th[0] = '{x: 34'(dhjt_pkg::CORDIC_GAIN), y: '0, z: {4'b0, th32[29:0]}};
  assign al[0] = '{x: 34'(dhjt_pkg::CORDIC_GAIN), y: '0, z: {4'b0, al32[29:0]}};
  assign side[0] = {th32[31:30], al32[31:30], a_r, d_r};

  for (genvar g = 0; g < N; g++) begin : g_cell
    dhjt_cordic_cell #(.STEP(g), .SIDE_W(SW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_in(vld[g]), .th_in(th[g]), .al_in(al[g]), .side_in(side[g]),
      .vld_out(vld[g+1]), .th_out(th[g+1]), .al_out(al[g+1]), .side_out(side[g+1])
    );
  end

  function automatic logic signed [33:0] rnd_clamp(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = (v + (34'sd1 <<< (29 - F))) >>> (30 - F);
      if (r > ONE)       r = ONE;
      else if (r < -ONE) r = -ONE;
      return r;
    end
  endfunction

  // quadrant map
  logic               q_vld_r;
  logic signed [TW-1:0] st_r, ct_r, sa_r, ca_r;
  logic signed [TW-1:0] st_nxt, ct_nxt, sa_nxt, ca_nxt;
  logic signed [LW-1:0] qa_r, qd_r;
  logic signed [33:0]   tx, ty, ax, ay;
  logic [1:0]           tq, aq;

  always_comb begin
    tx = rnd_clamp(th[N].x); ty = rnd_clamp(th[N].y);
    ax = rnd_clamp(al[N].x); ay = rnd_clamp(al[N].y);
    tq = side[N][SW-1 -: 2];
    aq = side[N][SW-3 -: 2];
    case (tq)
      2'd0:    begin ct_nxt = TW'(tx);  st_nxt = TW'(ty);  end
      2'd1:    begin ct_nxt = TW'(-ty); st_nxt = TW'(tx);  end
      2'd2:    begin ct_nxt = TW'(-tx); st_nxt = TW'(-ty); end
      default: begin ct_nxt = TW'(ty);  st_nxt = TW'(-tx); end
    endcase
    case (aq)
      2'd0:    begin ca_nxt = TW'(ax);  sa_nxt = TW'(ay);  end
      2'd1:    begin ca_nxt = TW'(-ay); sa_nxt = TW'(ax);  end
      2'd2:    begin ca_nxt = TW'(-ax); sa_nxt = TW'(-ay); end
      default: begin ca_nxt = TW'(ay);  sa_nxt = TW'(-ax); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_vld_r <= 1'b0;
    else        q_vld_r <= vld[N];
    st_r <= st_nxt; ct_r <= ct_nxt; sa_r <= sa_nxt; ca_r <= ca_nxt;
    qa_r <= side[N][2*LW-1:LW];
    qd_r <= side[N][LW-1:0];
  end

  // products, registered raw
  logic                 p_vld_r;
  logic signed [2*TW-1:0] p01_r, p02_r, p11_r, p12_r;
  logic signed [LW+TW-1:0] px_r, py_r;
  logic signed [TW-1:0] p_st_r, p_ct_r, p_sa_r, p_ca_r;
  logic signed [LW-1:0] p_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else        p_vld_r <= q_vld_r;
    p01_r <= -(st_r * ca_r);
    p02_r <= st_r * sa_r;
    p11_r <= ct_r * ca_r;
    p12_r <= -(ct_r * sa_r);
    px_r  <= qa_r * ct_r;
    py_r  <= qa_r * st_r;
    p_st_r <= st_r; p_ct_r <= ct_r; p_sa_r <= sa_r; p_ca_r <= ca_r;
    p_d_r <= qd_r;
  end

  function automatic logic signed [TW-1:0] trig_rs(input logic signed [2*TW-1:0] p);
    logic signed [2*TW:0] r;
    begin
      r = ($signed({p[2*TW-1], p}) + ((2*TW+1)'(1) <<< (F-1))) >>> F;
      if (r > (2*TW+1)'(ONE))       r = (2*TW+1)'(ONE);
      else if (r < -(2*TW+1)'(ONE)) r = -(2*TW+1)'(ONE);
      return r[TW-1:0];
    end
  endfunction

  function automatic logic signed [LW-1:0] len_rs(input logic signed [LW+TW-1:0] p);
    logic signed [LW+TW:0] r;
    begin
      r = ($signed({p[LW+TW-1], p}) + ((LW+TW+1)'(1) <<< (F-1))) >>> F;
      if (r > (LW+TW+1)'(LMAX))      r = (LW+TW+1)'(LMAX);
      else if (r < (LW+TW+1)'(LMIN)) r = (LW+TW+1)'(LMIN);
      return r[LW-1:0];
    end
  endfunction

  // output register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= p_vld_r;
    out_rot_00  <= p_ct_r;
    out_rot_01  <= trig_rs(p01_r);
    out_rot_02  <= trig_rs(p02_r);
    out_rot_10  <= p_st_r;
    out_rot_11  <= trig_rs(p11_r);
    out_rot_12  <= trig_rs(p12_r);
    out_rot_21  <= p_sa_r;
    out_rot_22  <= p_ca_r;
    out_trans_x <= len_rs(px_r);
    out_trans_y <= len_rs(py_r);
    out_trans_z <= p_d_r;
  end
  assign out_valid = out_valid_r;

endmodule

// File: rtl/dhjt_checker.sv
// ---------------------------------------------------------------------------
// dhjt_checker
// Port-level checks on the DH joint transform, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module dhjt_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic signed [15:0] out_rot_00,
  input logic signed [15:0] out_rot_21
);
  logic rot00_ok, rot21_ok;

  assign rot00_ok = (out_rot_00 <= 16'sd16384) && (out_rot_00 >= -16'sd16384);
  assign rot21_ok = (out_rot_21 <= 16'sd16384) && (out_rot_21 >= -16'sd16384);

  `ASSERT_CLK(a_lat, clk, rst_n, (start && !busy) |-> ##35 out_valid, "result missing")
  `ASSERT_CLK(a_noextra, clk, rst_n, out_valid |-> $past(start && !busy, 35), "extra result")
  `ASSERT_CLK(a_rng, clk, rst_n, out_valid |-> (rot00_ok && rot21_ok), "trig out of range")
  `ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_valid, "valid after reset")
endmodule

bind dh_joint_transform dhjt_checker u_dhjt_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_rot_00(out_rot_00), .out_rot_21(out_rot_21)
);
